// File: rtl/switch_pattern_sequencer_assert.svh
// Assertion macros for the switch pattern sequencer.
// Each check samples on the rising edge of clk and is off while rst_n is low.
`ifndef SWITCH_PATTERN_SEQUENCER_ASSERT_SVH
`define SWITCH_PATTERN_SEQUENCER_ASSERT_SVH

`ifndef SYNTH

`define SPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SPS_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define SPS_ASSERT(lbl, prop, msg)

`define SPS_ASSERT_NEXT(lbl, cond, prop, msg)

`endif

`endif

// File: rtl/sps_pkg.sv
`timescale 1ns / 1ps

package sps_pkg;

    localparam int PATTERN_W = 4;
    localparam logic [31:0] MIN_PERIOD = 32'd50;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_START  = 3'd1,
        CMD_HALT   = 3'd2,
        CMD_STEP   = 3'd3,
        CMD_DIRECT = 3'd4,
        CMD_REWIND = 3'd5
    } cmd_t;

    localparam logic [1:0] REG_PATTERN = 2'd0;
    localparam logic [1:0] REG_LENGTH  = 2'd1;
    localparam logic [1:0] REG_PERIOD  = 2'd2;

    typedef struct packed {
        logic [63:0] pattern_table;
        logic [4:0]  cycle_length;
        logic [31:0] period_ticks;
    } seq_cfg_t;

    typedef struct packed {
        logic [3:0]  line_levels;
        logic [3:0]  step_pointer;
        logic        active;
        logic [31:0] period_count;
        logic [31:0] time_count;
        logic [31:0] last_start;
    } seq_state_t;

    function automatic logic [3:0] pattern_at(input logic [63:0] table_bits,
                                              input logic [3:0] idx);
        pattern_at = table_bits[{idx, 2'b00} +: PATTERN_W];
    endfunction

endpackage

// File: rtl/sps_step.sv
`timescale 1ns / 1ps

module sps_step import sps_pkg::*; #(
    parameter int MAX_STEPS = 16
) (
    input  seq_cfg_t   cfg,
    input  seq_state_t cur,
    input  logic [2:0] command,
    input  logic [3:0] direct_pins,
    output seq_state_t nxt,
    output logic       accepted
);

    localparam logic [4:0] MaxLen = 5'(MAX_STEPS);

    logic [4:0]  eff_len;
    logic        has_cycle;
    logic [4:0]  adv_idx;
    logic [3:0]  adv_ptr;
    logic [3:0]  adv_pat;
    logic [31:0] period_inc;

    // effective length saturates at the table depth
    assign eff_len   = (cfg.cycle_length > MaxLen) ? MaxLen : cfg.cycle_length;
    assign has_cycle = (eff_len != 5'd0);
    assign adv_idx   = {1'b0, cur.step_pointer} + 5'd1;
    assign adv_ptr   = (adv_idx >= eff_len) ? 4'd0 : adv_idx[3:0];
    assign adv_pat   = pattern_at(cfg.pattern_table, adv_ptr);
    assign period_inc = cur.period_count + 32'd1;

    always_comb
    begin
        nxt      = cur;
        accepted = 1'b1;
        case (command)
            CMD_TICK:
            begin
                nxt.time_count = cur.time_count + 32'd1;
                if (cur.active)
                begin
                    if (period_inc >= cfg.period_ticks)
                    begin
                        nxt.period_count = '0;
                        if (has_cycle)
                        begin
                            nxt.step_pointer = adv_ptr;
                            nxt.line_levels  = adv_pat;
                        end
                    end
                    else
                    begin
                        nxt.period_count = period_inc;
                    end
                end
            end
            CMD_START:
            begin
                if (!has_cycle || (cfg.period_ticks < MIN_PERIOD))
                begin
                    accepted = 1'b0;
                end
                else
                begin
                    nxt.line_levels  = pattern_at(cfg.pattern_table, cur.step_pointer);
                    nxt.last_start   = cur.time_count;
                    nxt.period_count = '0;
                    nxt.active       = 1'b1;
                end
            end
            CMD_HALT:
            begin
                nxt.active      = 1'b0;
                nxt.line_levels = '0;
            end
            CMD_STEP:
            begin
                if (!has_cycle)
                begin
                    accepted = 1'b0;
                end
                else
                begin
                    nxt.step_pointer = adv_ptr;
                    nxt.line_levels  = adv_pat;
                end
            end
            CMD_DIRECT:
            begin
                nxt.active      = 1'b0;
                nxt.line_levels = direct_pins;
            end
            CMD_REWIND:
            begin
                nxt.active       = 1'b0;
                nxt.line_levels  = '0;
                nxt.step_pointer = '0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// File: rtl/switch_pattern_sequencer.sv
`timescale 1ns / 1ps
// Channel    | Handshake                 | Payload
// -----------+---------------------------+----------------------------------------------
// command in | in_valid / in_ready       | command[2:0], direct_pins[3:0]
// result out | out_valid / out_ready     | pins, step_index, running, accepted, start_time
// register   | cfg_valid / cfg_ready     | cfg_index[1:0], cfg_data[63:0]
//
// Throughput is one command per cycle while the result side is not stalled; each
// command yields one result, through the input register, then the result register.
// The rate is set by the combinational next-state logic: the period compare and
// the 16-way pattern select sit between the input register and the state.
// Reset clears the sequencer state, the configuration and both valid flags.
// A stalled result holds the input register; the input side stalls only when
// both the input register and the result register are full.

`include "switch_pattern_sequencer_assert.svh"

module switch_pattern_sequencer import sps_pkg::*; #(
    parameter int MAX_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [3:0]  direct_pins,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  pins,
    output logic [3:0]  step_index,
    output logic        running,
    output logic        accepted,
    output logic [31:0] start_time,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // configuration registers
    seq_cfg_t   cfg_reg;

    // sequencer state
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       accepted_next;

    // input register
    logic       s1_valid_reg;
    logic [2:0] s1_cmd_reg;
    logic [3:0] s1_direct_reg;
    logic       s1_adv;

    // result register
    logic        out_valid_reg;
    logic [3:0]  pins_reg;
    logic [3:0]  step_index_reg;
    logic        running_reg;
    logic        accepted_reg;
    logic [31:0] start_time_reg;

    // the result register frees up when it is empty or its transfer completes
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    // register writes are always taken; an index beyond the list is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PATTERN: cfg_reg.pattern_table <= cfg_data;
                REG_LENGTH:  cfg_reg.cycle_length  <= cfg_data[4:0];
                REG_PERIOD:  cfg_reg.period_ticks  <= cfg_data[31:0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // capture the command transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg    <= command;
            s1_direct_reg <= direct_pins;
        end
    end

    sps_step #(
        .MAX_STEPS (MAX_STEPS)
    ) u_step (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .command     (s1_cmd_reg),
        .direct_pins (s1_direct_reg),
        .nxt         (state_next),
        .accepted    (accepted_next)
    );

    // commit the state only when the command moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s1_adv)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload: hold until the transfer completes
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            pins_reg       <= state_next.line_levels;
            step_index_reg <= state_next.step_pointer;
            running_reg    <= state_next.active;
            accepted_reg   <= accepted_next;
            start_time_reg <= state_next.last_start;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pins       = pins_reg;
    assign step_index = step_index_reg;
    assign running    = running_reg;
    assign accepted   = accepted_reg;
    assign start_time = start_time_reg;

    `SPS_ASSERT(a_ready_when_empty, !s1_valid_reg |-> in_ready, "input side stalled while empty")
    `SPS_ASSERT_NEXT(a_held_command, s1_valid_reg && !s1_adv, s1_valid_reg, "held command dropped")
    `SPS_ASSERT_NEXT(a_result_follows, s1_adv, out_valid_reg, "committed command lost its result")
    `SPS_ASSERT_NEXT(a_refused_no_change, s1_adv && !accepted_next,
        state_reg == $past(state_reg), "refused command changed the state")

endmodule

// File: test/switch_pattern_sequencer_test.sv
`timescale 1ns / 1ps

module switch_pattern_sequencer_test;
    import sps_pkg::*;

    localparam int MAX_STEPS    = 16;
    localparam int RANDOM_ITEMS = 1650;
    // Generous ceiling: ~1700 commands, each behind a sender gap and a sparse
    // receiver, plus the drains around every register write.
    localparam int CYCLE_LIMIT  = 400000;

    // One result per command transfer: the sequencer status after it.
    typedef struct packed {
        logic [3:0]  pins;
        logic [3:0]  step_index;
        logic        running;
        logic        accepted;
        logic [31:0] start_time;
    } status_t;

    // Receiver stall styles; the back-pressure block below picks a new one at random.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_MOSTLY
    } ready_style_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [2:0]  command     = CMD_TICK;
    logic [3:0]  direct_pins = 4'd0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [3:0]  pins;
    logic [3:0]  step_index;
    logic        running;
    logic        accepted;
    logic [31:0] start_time;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = REG_PATTERN;
    logic [63:0] cfg_data    = '0;

    switch_pattern_sequencer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .direct_pins (direct_pins),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pins        (pins),
        .step_index  (step_index),
        .running     (running),
        .accepted    (accepted),
        .start_time  (start_time),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Predicted sequencer: shadow registers and shadow state.
    logic [63:0] cfg_table  = '0;
    logic [4:0]  cfg_len    = '0;
    logic [31:0] cfg_period = '0;
    logic [3:0]  seq_lines    = '0;
    logic [3:0]  seq_index    = '0;
    logic        seq_active   = 1'b0;
    logic [31:0] period_count = '0;
    logic [31:0] tick_count   = '0;
    logic [31:0] start_mark   = '0;

    // Status words still owed by the block, oldest first.
    status_t expected_status[$];

    bit           failed      = 1'b0;
    int           items_sent  = 0;
    int           burst_left  = 0;
    bit           gaps_on     = 1'b1;
    int           cycle_count = 0;
    logic [7:0]   ready_ticker = '0;
    ready_style_t ready_style  = READY_ALWAYS;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort on a hang; a correct run never comes close.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver back-pressure: pick a new style whenever the low six ticker bits are zero,
    // so stalls land on every phase of the result pipeline, with full-rate stretches too.
    always @(posedge clk)
    begin
        ready_ticker <= ready_ticker + 8'd1;
        if (ready_ticker[5:0] == 6'd0)
            ready_style <= ready_style_t'($urandom_range(0, 3));
        case (ready_style)
            READY_ALWAYS: out_ready <= 1'b1;
            READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: out_ready <= (ready_ticker[1:0] == 2'd0);
            default:      out_ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------

    // Cycle length saturated to the table depth.
    function automatic logic [4:0] steps_in_use();
        return (cfg_len > 5'(MAX_STEPS)) ? 5'(MAX_STEPS) : cfg_len;
    endfunction

    function automatic logic [3:0] pattern_of(input logic [3:0] idx);
        return cfg_table[int'(idx) * 4 +: 4];
    endfunction

    // Move to the next step, wrapping at the cycle length; no-op with no cycle.
    function automatic void step_forward();
        logic [4:0] n;
        logic [4:0] nxt;
        n = steps_in_use();
        if (n == 5'd0)
            return;
        nxt = {1'b0, seq_index} + 5'd1;
        if (nxt >= n)
            nxt = 5'd0;
        seq_index = nxt[3:0];
        seq_lines = pattern_of(seq_index);
    endfunction

    function automatic void lines_off();
        seq_active = 1'b0;
        seq_lines  = 4'd0;
    endfunction

    // Apply one command to the shadow state and return the status it yields.
    function automatic status_t apply_command(input cmd_t cmd, input logic [3:0] dp);
        status_t st;
        st.accepted = 1'b1;
        case (cmd)
            CMD_TICK:
            begin
                tick_count = tick_count + 32'd1;
                if (seq_active)
                begin
                    period_count = period_count + 32'd1;
                    if (period_count >= cfg_period)
                    begin
                        period_count = '0;
                        step_forward();
                    end
                end
            end
            CMD_START:
            begin
                if (steps_in_use() == 5'd0 || cfg_period < MIN_PERIOD)
                    st.accepted = 1'b0;
                else
                begin
                    // Drive the held step even when it lies past the length.
                    seq_lines    = pattern_of(seq_index);
                    start_mark   = tick_count;
                    period_count = '0;
                    seq_active   = 1'b1;
                end
            end
            CMD_HALT:
                lines_off();
            CMD_STEP:
            begin
                if (steps_in_use() == 5'd0)
                    st.accepted = 1'b0;
                else
                    step_forward();
            end
            CMD_DIRECT:
            begin
                lines_off();
                seq_lines = dp;
            end
            CMD_REWIND:
            begin
                lines_off();
                seq_index = 4'd0;
            end
            default:
                ;
        endcase
        st.pins       = seq_lines;
        st.step_index = seq_index;
        st.running    = seq_active;
        st.start_time = start_mark;
        return st;
    endfunction

    // ---------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failed = 1'b1;
        end
    endtask

    // Compare every result transfer against the oldest owed status.
    always @(posedge clk)
    begin : check_results
        status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                failed = 1'b1;
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("pins", 32'(want.pins), 32'(pins));
                check_field("step_index", 32'(want.step_index), 32'(step_index));
                check_field("running", 32'(want.running), 32'(running));
                check_field("accepted", 32'(want.accepted), 32'(accepted));
                check_field("start_time", want.start_time, start_time);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus plumbing
    // ---------------------------------------------------------------------

    // Send one command. Bursts of random length; between bursts drop valid
    // for a random gap (when gaps are enabled). Valid stays high after the
    // transfer so back-to-back commands never lower and raise it in one step.
    task automatic send_command(input cmd_t cmd, input logic [3:0] dp);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        command     <= cmd;
        direct_pins <= dp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_status.push_back(apply_command(cmd, dp));
        items_sent++;
    endtask

    // Hold off the sender until every owed status has been received.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_status.size() != 0);
    endtask

    // Register write, only with the command pipeline drained.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PATTERN: cfg_table  = value;
            REG_LENGTH:  cfg_len    = value[4:0];
            REG_PERIOD:  cfg_period = value[31:0];
            default:     ;
        endcase
    endtask

    function automatic logic [63:0] pick_table();
        case ($urandom_range(0, 7))
            0:       return 64'hFFFF_FFFF_FFFF_FFFF;
            1:       return 64'h0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly periods just at or above the minimum so steps actually happen.
    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 49);
            1:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : $urandom;
            default: return $urandom_range(50, 58);
        endcase
    endfunction

    task automatic send_any_command();
        send_command(cmd_t'($urandom_range(0, 5)), 4'($urandom_range(0, 15)));
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Registers still at reset: no cycle, so start and step once are refused.
    task automatic test_idle_refusals();
        send_command(CMD_TICK, 4'd0);
        send_command(CMD_START, 4'd0);
        send_command(CMD_STEP, 4'd0);
        send_command(CMD_HALT, 4'd0);
        send_command(CMD_DIRECT, 4'hF);
        send_command(CMD_REWIND, 4'd0);
    endtask

    // Start needs a period of at least 50; exactly 50 is accepted.
    task automatic test_start_rules();
        write_reg(REG_PATTERN, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_LENGTH, 64'd16);
        write_reg(REG_PERIOD, 64'd49);
        send_command(CMD_START, 4'd0);
        write_reg(REG_PERIOD, 64'd50);
        send_command(CMD_START, 4'd0);
        send_command(CMD_STEP, 4'd0);
        send_command(CMD_HALT, 4'd0);
        send_command(CMD_DIRECT, 4'd0);
    endtask

    // Held index beyond a shortened cycle: start drives it, step once wraps.
    task automatic test_held_step_past_length();
        write_reg(REG_LENGTH, 64'd1);
        send_command(CMD_START, 4'd0);
        send_command(CMD_STEP, 4'd0);
    endtask

    // Period rewritten while running: period zero steps on every tick, the
    // maximum period never steps; restart captures the new tick count.
    task automatic test_period_change_running();
        write_reg(REG_LENGTH, 64'd3);
        write_reg(REG_PERIOD, 64'd50);
        send_command(CMD_START, 4'd0);
        write_reg(REG_PERIOD, 64'd0);
        repeat (4)
            send_command(CMD_TICK, 4'd0);
        write_reg(REG_PERIOD, 64'hFFFF_FFFF);
        send_command(CMD_TICK, 4'd0);
        write_reg(REG_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF);
        send_command(CMD_START, 4'd0);
        send_command(CMD_HALT, 4'd0);
    endtask

    // Random phases: mostly well-formed runs (configure, start, tick with
    // the odd stray command), some period rewrites mid-run, some noise.
    task automatic test_random_runs();
        int stop_at;
        int kind;
        int n;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            kind    = $urandom_range(0, 9);
            gaps_on = ($urandom_range(0, 3) != 0);
            if (kind < 6)
            begin
                if ($urandom_range(0, 9) < 7)
                    write_reg(REG_PATTERN, pick_table());
                write_reg(REG_LENGTH, ($urandom_range(0, 7) == 0) ? 64'd0
                                                                   : 64'($urandom_range(1, 16)));
                write_reg(REG_PERIOD, 64'(pick_period()));
                if ($urandom_range(0, 1) != 0)
                    send_command(CMD_REWIND, 4'($urandom_range(0, 15)));
                send_command(CMD_START, 4'($urandom_range(0, 15)));
                n = $urandom_range(40, 180);
                repeat (n)
                begin
                    if ($urandom_range(0, 99) < 8)
                        send_command(cmd_t'($urandom_range(1, 5)), 4'($urandom_range(0, 15)));
                    else
                        send_command(CMD_TICK, 4'($urandom_range(0, 15)));
                end
            end
            else if (kind < 8)
            begin
                // Get running under the current setting, then shrink the period.
                if (!seq_active)
                    send_command(CMD_START, 4'($urandom_range(0, 15)));
                write_reg(REG_PERIOD, 64'($urandom_range(0, 12)));
                n = $urandom_range(20, 60);
                repeat (n)
                begin
                    if ($urandom_range(0, 99) < 5)
                        send_any_command();
                    else
                        send_command(CMD_TICK, 4'($urandom_range(0, 15)));
                end
            end
            else
            begin
                write_reg(REG_LENGTH, 64'($urandom_range(0, 16)));
                write_reg(REG_PERIOD, 64'($urandom_range(0, 60)));
                n = $urandom_range(20, 60);
                repeat (n)
                    send_any_command();
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial
    begin
        // Hold reset at the start, then release it for good.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_refusals();
        test_start_rules();
        test_held_step_past_length();
        test_period_change_running();
        test_random_runs();

        // Drain, then allow the two-stage pipeline to settle.
        wait_for_results();
        repeat (4) @(posedge clk);
        if (!failed && expected_status.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
